>>> hw/rtl/block_average_downsample_macros.svh
// Assertion macros shared by the block average downsampler RTL.
// Depends on nothing; included by the files that assert.
`ifndef BLOCK_AVERAGE_DOWNSAMPLE_MACROS_SVH
`define BLOCK_AVERAGE_DOWNSAMPLE_MACROS_SVH

`ifndef ASSERT_OFF
`define BAVG_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BAVG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BAVG_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define BAVG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/bavg_pkg.sv
// Shared constants, register indexes and control structs of the block
// average downsampler. Depends on nothing.
`default_nettype none

package bavg_pkg;

  localparam int MAX_OVER_COLS = 4096;
  localparam int COL_W         = $clog2(MAX_OVER_COLS);
  localparam int ROW_LIMIT     = 4096;
  localparam int ROW_W         = $clog2(ROW_LIMIT);
  localparam int MAX_SCALE     = 16;
  localparam int SUB_W         = $clog2(MAX_SCALE);
  localparam int SAMPLE_W      = 32;
  localparam int ACC_W         = 40;
  localparam int DSR_W         = 9;
  localparam int QCNT_W        = $clog2(ACC_W);
  localparam int DIM_W         = 13;
  localparam int PAD_W         = 11;
  localparam int SCALE_W       = 5;
  localparam int START_W       = 14;
  localparam int MAIN_W        = 15;
  localparam int ADDR_W        = 28;
  localparam int AVG_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVER_COLS = 3'd0,
    REG_OVER_ROWS = 3'd1,
    REG_PAD_COLS  = 3'd2,
    REG_PAD_ROWS  = 3'd3,
    REG_SCALE     = 3'd4,
    REG_START_COL = 3'd5,
    REG_START_ROW = 3'd6,
    REG_MAIN_COLS = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_AVG = 2'd0,
    DIV_COL = 2'd1,
    DIV_ROW = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     acc_write;
    logic     div_start;
    div_sel_t div_sel;
    logic     load_col;
    logic     load_row;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/bavg_if.sv
// Valid/ready channel interfaces for pixel input and binned output.
// Depends on bavg_pkg for field widths.
`default_nettype none

interface bavg_in_if;
  import bavg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       frame_start;
  modport source (output valid, output sample, output frame_start, input ready);
  modport sink (input valid, input sample, input frame_start, output ready);
endinterface

interface bavg_out_if;
  import bavg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [AVG_W-1:0] average;
  logic [START_W-1:0]      dest_row;
  logic [START_W-1:0]      dest_col;
  logic [ADDR_W-1:0]       dest_address;
  logic                    frame_last;
  modport source (output valid, output average, output dest_row, output dest_col,
                  output dest_address, output frame_last, input ready);
  modport sink (input valid, input average, input dest_row, input dest_col,
                input dest_address, input frame_last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/block_average_downsample.sv
// Top level of the block average downsampler: controller plus datapath.
// Depends on bavg_pkg, bavg_if, bavg_ctrl, bavg_dp and the assertion macros.
//
// Usage: oversampled pixels enter on pix_in (valid/ready) in raster order,
// padding included; frame_start on a transfer restarts the position at the
// top left. Binned averages leave on pix_out with destination row, column,
// linear address and a last-of-region flag. Registers are written through
// cfg_write/cfg_index/cfg_data while the block is idle.
// Per pixel: a pixel that completes no bin is accepted, then its accumulator
// read-modify-write runs in the line memory. A pixel that completes a bin
// then also needs the divider start, the bit-serial divide (one quotient
// bit per cycle over the 40-bit sum) and the output load.
// After any register write the block recomputes its bin position with
// the same divider before it accepts the next pixel.
// Reset restores the register defaults and zeroes the position counters;
// accumulator contents are not cleared. While the receiver stalls, one
// finished result waits in the output register and input keeps flowing
// until the next completed bin needs that register.
`default_nettype none
`include "block_average_downsample_macros.svh"

module block_average_downsample (
  input  wire logic                            clk,
  input  wire logic                            rst,
  bavg_in_if.sink                              pix_in,
  bavg_out_if.source                           pix_out,
  input  wire logic                            cfg_write,
  input  wire logic [bavg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bavg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bavg_pkg::*;

  cmd_t    cmd;
  status_t status;

  bavg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bavg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (pix_in.sample),
    .frame_start  (pix_in.frame_start),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (pix_out.ready),
    .out_valid    (pix_out.valid),
    .average      (pix_out.average),
    .dest_row     (pix_out.dest_row),
    .dest_col     (pix_out.dest_col),
    .dest_address (pix_out.dest_address),
    .frame_last   (pix_out.frame_last)
  );

  `BAVG_ASSERT_NEXT(a_accept_then_acc, clk, rst, pix_in.valid && pix_in.ready, cmd.acc_write)
  `BAVG_ASSERT_NEXT(a_div_not_instant, clk, rst, cmd.div_start, !status.div_done)
  `BAVG_ASSERT_NEXT(a_cfg_blocks_input, clk, rst, cfg_write, !pix_in.ready)
  `BAVG_ASSERT_IMPLY(a_load_when_free, clk, rst, cmd.out_load, status.out_free)

endmodule

`default_nettype wire

>>> hw/rtl/bavg_div.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on bavg_pkg for widths.
`default_nettype none

module bavg_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [bavg_pkg::ACC_W-1:0] dividend,
  input  wire logic [bavg_pkg::DSR_W-1:0] divisor,
  output logic                            done,
  output logic [bavg_pkg::ACC_W-1:0]      quotient,
  output logic [bavg_pkg::DSR_W-1:0]      remainder
);
  import bavg_pkg::*;

  logic              busy;
  logic [QCNT_W-1:0] cnt;
  logic [ACC_W-1:0]  quo;
  logic [DSR_W-1:0]  rem;
  logic [DSR_W-1:0]  dsr;
  logic [DSR_W:0]    shifted;
  logic [DSR_W:0]    diff;
  logic              fits;

  always_comb begin
    shifted = {rem, quo[ACC_W-1]};
    diff    = shifted - {1'b0, dsr};
    fits    = shifted >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
        quo <= {quo[ACC_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == QCNT_W'(ACC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

>>> hw/rtl/bavg_dp.sv
// Datapath: configuration registers, position counters, accumulator line
// memory, output register. Depends on bavg_pkg and bavg_div.
`default_nettype none

module bavg_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [bavg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bavg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [bavg_pkg::SAMPLE_W-1:0]   sample,
  input  wire logic                            frame_start,
  input  wire bavg_pkg::cmd_t                  cmd,
  output bavg_pkg::status_t                    status,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [bavg_pkg::AVG_W-1:0]           average,
  output logic [bavg_pkg::START_W-1:0]         dest_row,
  output logic [bavg_pkg::START_W-1:0]         dest_col,
  output logic [bavg_pkg::ADDR_W-1:0]          dest_address,
  output logic                                 frame_last
);
  import bavg_pkg::*;

  logic [DIM_W-1:0]   over_cols, over_rows;
  logic [PAD_W-1:0]   pad_cols, pad_rows;
  logic [SCALE_W-1:0] scale;
  logic [START_W-1:0] start_col, start_row;
  logic [MAIN_W-1:0]  main_cols;

  logic [COL_W-1:0] pixel_col, bin_col;
  logic [ROW_W-1:0] pixel_row, bin_row;
  logic [SUB_W-1:0] sub_col, sub_row;

  logic [ACC_W-1:0] bin_sums [MAX_OVER_COLS];
  logic [ACC_W-1:0] rd_data;

  logic [ACC_W-1:0] st_sample, sum_reg, acc_sum;
  logic             st_start, st_in, st_emit, st_last;
  logic [COL_W-1:0] st_bc;
  logic [ROW_W-1:0] st_br;
  logic [START_W-1:0] dr, dc;
  logic             flast;
  logic [START_W+MAIN_W-1:0] prod;

  logic [DIM_W-1:0]   oc_cl, or_cl, w_c, w_r, pad2_c, pad2_r;
  logic [SCALE_W-1:0] s_cl, sm1;
  logic [2*SCALE_W-1:0] sq;
  logic               has_c, has_r, ge_c, ge_r, in_c, in_r, last_c, last_r;
  logic               emit_c, emit_r, wrap_c;
  logic [COL_W-1:0]   eff_pc, eff_bc, npc;
  logic [ROW_W-1:0]   eff_pr, eff_br, npr;
  logic [SUB_W-1:0]   eff_sc, eff_sr;
  logic [DIM_W-1:0]   rel_c, rel_r, end_c, end_r, pc_inc, pr_inc;
  logic [COL_W-1:0]   bin_col_next;
  logic [ROW_W-1:0]   bin_row_next;
  logic [SUB_W-1:0]   sub_col_next, sub_row_next;
  logic [ROW_W-1:0]   pixel_row_next;

  logic [ACC_W-1:0] div_dividend, div_quo;
  logic [DSR_W-1:0] div_divisor, div_rem;
  logic             div_done;
  logic [COL_W-1:0] rc_col;
  logic [ROW_W-1:0] rc_row;
  logic [ACC_W-1:0] avg_full;

  always_comb begin
    oc_cl = (over_cols == '0) ? DIM_W'(1) :
            (over_cols > DIM_W'(MAX_OVER_COLS)) ? DIM_W'(MAX_OVER_COLS) : over_cols;
    or_cl = (over_rows == '0) ? DIM_W'(1) :
            (over_rows > DIM_W'(ROW_LIMIT)) ? DIM_W'(ROW_LIMIT) : over_rows;
    s_cl  = (scale == '0) ? SCALE_W'(1) :
            (scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale;
    sm1   = s_cl - 1'b1;
    sq    = s_cl * s_cl;

    pad2_c = {1'b0, pad_cols, 1'b0};
    pad2_r = {1'b0, pad_rows, 1'b0};
    has_c  = oc_cl > pad2_c;
    has_r  = or_cl > pad2_r;
    w_c    = oc_cl - pad2_c;
    w_r    = or_cl - pad2_r;

    eff_pc = frame_start ? '0 : pixel_col;
    eff_sc = frame_start ? '0 : sub_col;
    eff_bc = frame_start ? '0 : bin_col;
    eff_pr = frame_start ? '0 : pixel_row;
    eff_sr = frame_start ? '0 : sub_row;
    eff_br = frame_start ? '0 : bin_row;

    // A subpixel counts only when the last subpixel of its bin still lies
    // inside the usable width, which drops partial bins at the edges.
    ge_c   = {1'b0, eff_pc} >= {2'b0, pad_cols};
    rel_c  = {1'b0, eff_pc} - {2'b0, pad_cols};
    end_c  = rel_c + {{(DIM_W-SCALE_W){1'b0}}, sm1} - {{(DIM_W-SUB_W){1'b0}}, eff_sc};
    in_c   = has_c && ge_c && (end_c < w_c);
    last_c = (end_c + {{(DIM_W-SCALE_W){1'b0}}, s_cl}) >= w_c;
    emit_c = eff_sc == sm1[SUB_W-1:0];

    ge_r   = {1'b0, eff_pr} >= {2'b0, pad_rows};
    rel_r  = {1'b0, eff_pr} - {2'b0, pad_rows};
    end_r  = rel_r + {{(DIM_W-SCALE_W){1'b0}}, sm1} - {{(DIM_W-SUB_W){1'b0}}, eff_sr};
    in_r   = has_r && ge_r && (end_r < w_r);
    last_r = (end_r + {{(DIM_W-SCALE_W){1'b0}}, s_cl}) >= w_r;
    emit_r = eff_sr == sm1[SUB_W-1:0];

    pc_inc = {1'b0, eff_pc} + 1'b1;
    wrap_c = pc_inc >= oc_cl;
    npc    = wrap_c ? '0 : pc_inc[COL_W-1:0];
    if ({1'b0, npc} == {2'b0, pad_cols}) begin
      sub_col_next = '0;
      bin_col_next = '0;
    end else if (emit_c) begin
      sub_col_next = '0;
      bin_col_next = eff_bc + 1'b1;
    end else begin
      sub_col_next = eff_sc + 1'b1;
      bin_col_next = eff_bc;
    end

    pr_inc = {1'b0, eff_pr} + 1'b1;
    npr    = (pr_inc >= or_cl) ? '0 : pr_inc[ROW_W-1:0];
    if (!wrap_c) begin
      pixel_row_next = eff_pr;
      sub_row_next   = eff_sr;
      bin_row_next   = eff_br;
    end else if ({1'b0, npr} == {2'b0, pad_rows}) begin
      pixel_row_next = npr;
      sub_row_next   = '0;
      bin_row_next   = '0;
    end else if (emit_r) begin
      pixel_row_next = npr;
      sub_row_next   = '0;
      bin_row_next   = eff_br + 1'b1;
    end else begin
      pixel_row_next = npr;
      sub_row_next   = eff_sr + 1'b1;
      bin_row_next   = eff_br;
    end

    acc_sum = st_start ? st_sample : rd_data + st_sample;

    rc_col = pixel_col - {1'b0, pad_cols};
    rc_row = pixel_row - {1'b0, pad_rows};
    unique case (cmd.div_sel)
      DIV_AVG: begin
        div_dividend = sum_reg[ACC_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        div_divisor  = sq[DSR_W-1:0];
      end
      DIV_COL: begin
        div_dividend = {{(ACC_W-COL_W){1'b0}}, rc_col};
        div_divisor  = {{(DSR_W-SCALE_W){1'b0}}, s_cl};
      end
      DIV_ROW: begin
        div_dividend = {{(ACC_W-ROW_W){1'b0}}, rc_row};
        div_divisor  = {{(DSR_W-SCALE_W){1'b0}}, s_cl};
      end
      default: begin
        div_dividend = '0;
        div_divisor  = {{(DSR_W-1){1'b0}}, 1'b1};
      end
    endcase

    avg_full = sum_reg[ACC_W-1] ? (~div_quo + 1'b1) : div_quo;
  end

  bavg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      over_cols <= DIM_W'(4096);
      over_rows <= DIM_W'(4096);
      pad_cols  <= '0;
      pad_rows  <= '0;
      scale     <= SCALE_W'(1);
      start_col <= '0;
      start_row <= '0;
      main_cols <= MAIN_W'(16384);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OVER_COLS: over_cols <= cfg_data[DIM_W-1:0];
        REG_OVER_ROWS: over_rows <= cfg_data[DIM_W-1:0];
        REG_PAD_COLS:  pad_cols  <= cfg_data[PAD_W-1:0];
        REG_PAD_ROWS:  pad_rows  <= cfg_data[PAD_W-1:0];
        REG_SCALE:     scale     <= cfg_data[SCALE_W-1:0];
        REG_START_COL: start_col <= cfg_data[START_W-1:0];
        REG_START_ROW: start_row <= cfg_data[START_W-1:0];
        REG_MAIN_COLS: main_cols <= cfg_data[MAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_col <= '0;
      pixel_row <= '0;
      sub_col   <= '0;
      sub_row   <= '0;
      bin_col   <= '0;
      bin_row   <= '0;
    end else if (cmd.accept) begin
      pixel_col <= npc;
      pixel_row <= pixel_row_next;
      sub_col   <= sub_col_next;
      sub_row   <= sub_row_next;
      bin_col   <= bin_col_next;
      bin_row   <= bin_row_next;
    end else begin
      if (cmd.load_col) begin
        sub_col <= div_rem[SUB_W-1:0];
        bin_col <= div_quo[COL_W-1:0];
      end
      if (cmd.load_row) begin
        sub_row <= div_rem[SUB_W-1:0];
        bin_row <= div_quo[ROW_W-1:0];
      end
    end
  end

  // Accumulator line: read in the accept cycle, written back in the following cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data <= bin_sums[eff_bc];
    end
    if (cmd.acc_write && st_in) begin
      bin_sums[st_bc] <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      st_sample <= {{(ACC_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
      st_start  <= (eff_sc == '0) && (eff_sr == '0);
      st_in     <= in_c && in_r;
      st_emit   <= emit_c && emit_r;
      st_last   <= last_c && last_r;
      st_bc     <= eff_bc;
      st_br     <= eff_br;
    end
    if (cmd.acc_write) begin
      sum_reg <= acc_sum;
      dr      <= start_row + {{(START_W-ROW_W){1'b0}}, st_br};
      dc      <= start_col + {{(START_W-COL_W){1'b0}}, st_bc};
      flast   <= st_last;
    end
    prod <= {{MAIN_W{1'b0}}, dr} * {{START_W{1'b0}}, main_cols};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average      <= avg_full[AVG_W-1:0];
      dest_row     <= dr;
      dest_col     <= dc;
      dest_address <= ADDR_W'(prod + {{MAIN_W{1'b0}}, dc});
      frame_last   <= flast;
    end
  end

  always_comb begin
    status.emit     = st_in && st_emit;
    status.div_done = div_done;
    status.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

>>> hw/rtl/bavg_ctrl.sv
// Controller state machine: sequences accumulation, the averaging divide
// and the counter recalculation after configuration writes. Uses bavg_pkg.
`default_nettype none

module bavg_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bavg_pkg::status_t   status,
  output bavg_pkg::cmd_t           cmd
);
  import bavg_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_ACC       = 9'b000000010,
    S_AVG_START = 9'b000000100,
    S_AVG_WAIT  = 9'b000001000,
    S_OUT       = 9'b000010000,
    S_COL_START = 9'b000100000,
    S_COL_WAIT  = 9'b001000000,
    S_ROW_START = 9'b010000000,
    S_ROW_WAIT  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   dirty;

  assign in_ready = (state == S_IDLE) && !dirty;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.div_sel   = DIV_AVG;
    cmd.accept    = in_ready && in_valid;
    unique case (state)
      S_IDLE: begin
        if (dirty) begin
          state_next = S_COL_START;
        end else if (in_valid) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_write = 1'b1;
        state_next    = status.emit ? S_AVG_START : S_IDLE;
      end
      S_AVG_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (status.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_COL_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_COL;
        state_next    = S_COL_WAIT;
      end
      S_COL_WAIT: begin
        cmd.div_sel = DIV_COL;
        if (status.div_done) begin
          cmd.load_col = 1'b1;
          state_next   = S_ROW_START;
        end
      end
      S_ROW_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ROW;
        state_next    = S_ROW_WAIT;
      end
      S_ROW_WAIT: begin
        cmd.div_sel = DIV_ROW;
        if (status.div_done) begin
          cmd.load_row = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dirty <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        dirty <= 1'b1;
      end else if (state == S_IDLE) begin
        dirty <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
